/* rtl/core/ptpc_pkg.sv */
// ----------------------------------------------------------------------------
// ptpc_pkg
// Shared types and constants of the PID temperature PWM controller: word
// formats, register indexes, opcodes, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package ptpc_pkg;

  // Datapath sizing
  localparam int PWM_WIDTH = 10;
  localparam int SUM_WIDTH = 32;

  localparam int TEMP_W   = 12;
  localparam int ERR_W    = TEMP_W + 1;
  localparam int DELTA_W  = ERR_W + 1;
  localparam int MAG_W    = ERR_W;
  localparam int GAIN_W   = 16;
  localparam int TICK_W   = 16;
  localparam int OFFSET_W = 11;
  localparam int PROD_W   = MAG_W + GAIN_W;
  localparam int DIV_W    = (SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W;
  localparam int CNT_W    = $clog2(DIV_W);
  localparam int DEN_W    = GAIN_W + 4;
  localparam int ACC_W    = DIV_W + 3;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd6;

  // Register reset values
  localparam int SETPOINT_RST  = 370;
  localparam int GAIN_PROP_RST = 474;
  localparam int SAMPLE_MS_RST = 500;
  localparam int INT_TIME_RST  = 370;
  localparam int GAIN_DER_RST  = 23;
  localparam int PWM_PER_RST   = 200;
  localparam int OFFSET_RST    = 1;

  // Divide by ten as multiply by reciprocal; exact for all 16-bit values
  localparam logic [TICK_W-1:0] RECIP10 = 16'd52429;
  localparam int RECIP10_SH = 19;
  localparam int THR_W      = 2 * TICK_W - RECIP10_SH;
  localparam int THR_RST    = SAMPLE_MS_RST / 10;

  // Q8.8 gain scaled by ten
  localparam int PD_DIVISOR = 256 * 10;

  // P and D scaling: drop the Q8.8 fraction, then divide by ten through a
  // reciprocal that is exact below 2^22
  localparam int PD_SHIFT    = 8;
  localparam int PD_SCL_W    = PROD_W - PD_SHIFT;
  localparam int RECIP10_W   = 20;
  localparam logic [RECIP10_W-1:0] RECIP10_WIDE = 20'd838861;
  localparam int RECIP10_WIDE_SH = 23;
  localparam int PD_MUL_W    = PD_SCL_W + RECIP10_W;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PWM    = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MULT   = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_ACC    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_D = 2'd1,
    TERM_I = 2'd2
  } term_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [TEMP_W-1:0] temperature;
  } in_word_t;

  typedef struct packed {
    logic                 pwm_level;
    logic [PWM_WIDTH-1:0] duty;
    logic                 control_updated;
  } out_word_t;

endpackage

/* rtl/core/pid_temperature_pwm_controller.sv */
// ----------------------------------------------------------------------------
// pid_temperature_pwm_controller
// Positional PID temperature controller with a counter-based PWM output.
// A control step runs P and D through one shared multiplier and a reciprocal
// scale, and I through a bit-serial restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
// Interval ticks, PWM ticks, early samples and ignored words give their result
//   in the cycle after acceptance; such words go one per cycle while the output
//   is not stalled. A sample that runs a control step passes P and D each through
//   multiply, load and accumulate states; the divider retires one quotient bit
//   per cycle for I, which is skipped when integral time is zero. Input stalls meanwhile.
// Reset: control state clears, datapath registers are not reset; configuration registers load defaults.
module pid_temperature_pwm_controller
  import ptpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_data_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_data_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Configuration registers
  logic signed [TEMP_W-1:0]   setpoint_q;
  logic [GAIN_W-1:0]          kp_q;
  logic [THR_W-1:0]           thr_q;
  logic [GAIN_W-1:0]          it_q;
  logic [GAIN_W-1:0]          kd_q;
  logic [PWM_WIDTH-1:0]       period_q;
  logic signed [OFFSET_W-1:0] offset_q;
  logic [2*TICK_W-1:0]        thr_prod;

  // Controller state
  state_e                       state_q, state_d;
  term_e                        term_q, term_d;
  logic [TICK_W-1:0]            interval_q, interval_d;
  logic signed [SUM_WIDTH-1:0]  err_sum_q, err_sum_d;
  logic signed [ERR_W-1:0]      prev_err_q, prev_err_d;
  logic [PWM_WIDTH-1:0]         duty_q, duty_d;
  logic [PWM_WIDTH-1:0]         pwm_cnt_q, pwm_cnt_d;
  logic                         level_q, level_d;
  logic                         out_valid_q, out_valid_d;

  // Datapath registers
  out_word_t                    out_q, out_d;
  logic signed [ERR_W-1:0]      e_q, e_d;
  logic signed [DELTA_W-1:0]    delta_q, delta_d;
  logic [PROD_W-1:0]            prod_q, prod_d;
  logic [DIV_W-1:0]             quo_q, quo_d;
  logic [DEN_W-1:0]             rem_q, rem_d;
  logic [DEN_W-1:0]             den_q, den_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         neg_q, neg_d;
  logic signed [ACC_W-1:0]      acc_q, acc_d;

  // Combinational helpers
  logic                         in_acc;
  logic                         step_c;
  logic signed [ERR_W-1:0]      e_c;
  logic signed [DELTA_W-1:0]    delta_c;
  logic signed [SUM_WIDTH:0]    sum_wide;
  logic signed [SUM_WIDTH-1:0]  sum_sat;
  logic [PWM_WIDTH:0]           pwm_inc;
  logic [PWM_WIDTH-1:0]         pwm_next;
  logic                         level_next;
  logic [MAG_W-1:0]             e_mag;
  logic [DELTA_W-1:0]           d_abs;
  logic [MAG_W-1:0]             mul_a;
  logic [GAIN_W-1:0]            mul_b;
  logic [PD_SCL_W-1:0]          pd_scaled;
  logic [PD_MUL_W-1:0]          pd_mul;
  logic [DIV_W-1:0]             pd_quot;
  logic [SUM_WIDTH-1:0]         s_abs;
  logic [DEN_W-1:0]             it10;
  logic [DEN_W:0]               div_shift;
  logic [DEN_W+1:0]             div_diff;
  logic                         div_fits;
  logic signed [ACC_W-1:0]      q_ext;
  logic signed [ACC_W-1:0]      ctl_out;
  logic signed [ACC_W-1:0]      period_ext;
  logic [PWM_WIDTH-1:0]         duty_clamp;
  logic                         load_out;

  // Handshake: busy during a step, or result register full and held
  assign in_stall_o  = (state_q != ST_IDLE) | (out_valid_q & out_stall_i);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Reduce sample period to 10 ms ticks when it is written
  assign thr_prod = cfg_wdata_i[TICK_W-1:0] * RECIP10;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= TEMP_W'(SETPOINT_RST);
      kp_q       <= GAIN_W'(GAIN_PROP_RST);
      thr_q      <= THR_W'(THR_RST);
      it_q       <= GAIN_W'(INT_TIME_RST);
      kd_q       <= GAIN_W'(GAIN_DER_RST);
      period_q   <= PWM_WIDTH'(PWM_PER_RST);
      offset_q   <= OFFSET_W'(OFFSET_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SETPOINT:  setpoint_q <= cfg_wdata_i[TEMP_W-1:0];
        CFG_GAIN_PROP: kp_q       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_SAMPLE_MS: thr_q      <= thr_prod[2*TICK_W-1:RECIP10_SH];
        CFG_INT_TIME:  it_q       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_DER:  kd_q       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_PWM_PER:   period_q   <= cfg_wdata_i[PWM_WIDTH-1:0];
        CFG_OFFSET:    offset_q   <= cfg_wdata_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Error, error delta and saturated error sum at sample acceptance
  assign step_c   = interval_q >= TICK_W'(thr_q);
  assign e_c      = {setpoint_q[TEMP_W-1], setpoint_q}
                  - {in_data_i.temperature[TEMP_W-1], in_data_i.temperature};
  assign delta_c  = {e_c[ERR_W-1], e_c} - {prev_err_q[ERR_W-1], prev_err_q};
  assign sum_wide = {err_sum_q[SUM_WIDTH-1], err_sum_q}
                  + {{(SUM_WIDTH+1-ERR_W){e_c[ERR_W-1]}}, e_c};

  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // Advance the PWM counter and wrap at the period
  assign pwm_inc    = {1'b0, pwm_cnt_q} + (PWM_WIDTH+1)'(1);
  assign pwm_next   = (pwm_inc >= {1'b0, period_q}) ? '0 : pwm_inc[PWM_WIDTH-1:0];
  assign level_next = pwm_next < duty_q;

  // Multiplier operands: magnitude of error or delta times a gain
  assign e_mag = e_q[ERR_W-1] ? MAG_W'(-e_q) : MAG_W'(e_q);
  assign d_abs = delta_q[DELTA_W-1] ? DELTA_W'(-delta_q) : DELTA_W'(delta_q);
  assign mul_a = (term_q == TERM_P) ? e_mag : d_abs[MAG_W-1:0];
  assign mul_b = (term_q == TERM_P) ? kp_q : kd_q;

  // Scale the P or D product down by 2560: shift out the fraction, then
  // multiply by the reciprocal of ten
  assign pd_scaled = prod_q[PROD_W-1:PD_SHIFT];
  assign pd_mul    = pd_scaled * RECIP10_WIDE;
  assign pd_quot   = DIV_W'(pd_mul[PD_MUL_W-1:RECIP10_WIDE_SH]);

  // Divider operands for the integral term
  assign s_abs = err_sum_q[SUM_WIDTH-1] ? SUM_WIDTH'(-err_sum_q) : SUM_WIDTH'(err_sum_q);
  assign it10  = ({4'b0000, it_q} << 3) + ({4'b0000, it_q} << 1);

  // Restoring divide step: one quotient bit per cycle
  assign div_shift = {rem_q, quo_q[DIV_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, den_q};
  assign div_fits  = ~div_diff[DEN_W+1];

  // Zero-extend the quotient magnitude; its sign is applied at accumulation (truncation toward zero)
  assign q_ext = {{(ACC_W-DIV_W){1'b0}}, quo_q};

  // Sum with bias and clamp to the PWM range; a negative sum gives a duty of one
  assign ctl_out    = acc_q + {{(ACC_W-OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};
  assign period_ext = {{(ACC_W-PWM_WIDTH){1'b0}}, period_q};

  always_comb begin
    if (ctl_out > period_ext) begin
      duty_clamp = period_q;
    end else if (ctl_out[ACC_W-1]) begin
      duty_clamp = PWM_WIDTH'(1);
    end else begin
      duty_clamp = ctl_out[PWM_WIDTH-1:0];
    end
  end

  // Sequencer and next-state logic
  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    interval_d  = interval_q;
    err_sum_d   = err_sum_q;
    prev_err_d  = prev_err_q;
    duty_d      = duty_q;
    pwm_cnt_d   = pwm_cnt_q;
    level_d     = level_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    e_d         = e_q;
    delta_d     = delta_q;
    prod_d      = prod_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    load_out    = 1'b0;

    // Drop the result word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.opcode)
            OP_TICK: begin
              if (interval_q != '1) begin
                interval_d = interval_q + TICK_W'(1);
              end
              load_out = 1'b1;
            end
            OP_PWM: begin
              pwm_cnt_d = pwm_next;
              level_d   = level_next;
              load_out  = 1'b1;
            end
            OP_SAMPLE: begin
              if (step_c) begin
                e_d        = e_c;
                delta_d    = delta_c;
                err_sum_d  = sum_sat;
                prev_err_d = e_c;
                interval_d = '0;
                acc_d      = '0;
                term_d     = TERM_P;
                state_d    = ST_MULT;
              end else begin
                load_out = 1'b1;
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      ST_MULT: begin
        prod_d  = mul_a * mul_b;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        rem_d = '0;
        cnt_d = CNT_W'(DIV_W - 1);
        if (term_q == TERM_I) begin
          quo_d   = DIV_W'(s_abs);
          den_d   = it10;
          neg_d   = err_sum_q[SUM_WIDTH-1];
          state_d = ST_DIV;
        end else begin
          quo_d   = pd_quot;
          neg_d   = (term_q == TERM_P) ? e_q[ERR_W-1] : delta_q[DELTA_W-1];
          state_d = ST_ACC;
        end
      end
      ST_DIV: begin
        rem_d = div_fits ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], div_fits};
        if (cnt_q == '0) begin
          state_d = ST_ACC;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_ACC: begin
        acc_d = neg_q ? (acc_q - q_ext) : (acc_q + q_ext);
        case (term_q)
          TERM_P: begin
            term_d  = TERM_D;
            state_d = ST_MULT;
          end
          TERM_D: begin
            term_d  = TERM_I;
            state_d = (it_q == '0) ? ST_FINISH : ST_LOAD;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_FINISH: begin
        duty_d                = duty_clamp;
        out_d.pwm_level       = level_q;
        out_d.duty            = duty_clamp;
        out_d.control_updated = 1'b1;
        out_valid_d           = 1'b1;
        state_d               = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // Present the result of a word that runs no control step
    if (load_out) begin
      out_d.pwm_level       = level_d;
      out_d.duty            = duty_q;
      out_d.control_updated = 1'b0;
      out_valid_d           = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_P;
      interval_q  <= '0;
      err_sum_q   <= '0;
      prev_err_q  <= '0;
      duty_q      <= '0;
      pwm_cnt_q   <= '0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      interval_q  <= interval_d;
      err_sum_q   <= err_sum_d;
      prev_err_q  <= prev_err_d;
      duty_q      <= duty_d;
      pwm_cnt_q   <= pwm_cnt_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    e_q     <= e_d;
    delta_q <= delta_d;
    prod_q  <= prod_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
    acc_q   <= acc_d;
  end

  // A step never overlaps a pending result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("result word pending during control step");

  // A stepping sample leaves the result register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.opcode == OP_SAMPLE) && step_c) |=> !out_valid_q)
    else $error("result word shown at start of control step");

  // Divider remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  // Finishing a step presents an updated result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> (out_valid_q && out_q.control_updated))
    else $error("control step finished without result word");

endmodule
